// File: src/peqd_pkg.sv
`default_nettype none
package peqd_pkg;
   localparam int DEPTH = 64;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_POP    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   localparam logic [2:0] ST_EMPTY    = 3'd0;
   localparam logic [2:0] ST_EVENT    = 3'd1;
   localparam logic [2:0] ST_QUIT     = 3'd2;
   localparam logic [2:0] ST_INSERTED = 3'd3;
   localparam logic [2:0] ST_DUP      = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;
   localparam logic [2:0] ST_REMOVED  = 3'd6;

   localparam logic [31:0] QUIT_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [15:0] prio;
      logic [15:0] source;
      logic [15:0] dest;
      logic [31:0] notice;
      logic [31:0] code;
      logic [31:0] param;
   } entry_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic      unique_mode;
      entry_type item;
   } cmd_type;
endpackage
`default_nettype wire

// File: src/priority_event_queue_dedup.sv
`default_nettype none
// Channel | Beat carries                                   | Handshake
// req     | tuser: func; tdata: source, dest, notice,      | req_tvalid/req_tready
//         | code, param, prio, unique                      |
// rsp     | tuser: status; tdata: source, dest, notice,    | rsp_tvalid/rsp_tready
//         | code, param, count                             |
// csr     | quit code                                      | csr_we
// Insert, pop and the unused code are accepted, then executed while the chain shifts.
// Remove is accepted, then the scan deletes the first matching entry until no match is left.
// Reset empties the chain at once; quit code returns to all ones.
// A beat is taken while a result waits; its execute cycle or final remove cycle
// stalls until the output register is free.
module priority_event_queue_dedup
   import peqd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // source[15:0] dest[31:16] notice[63:32] code[95:64] param[127:96] prio[143:128]
   // unique[144], zero fill
   input  wire logic [151:0] req_tdata,
   // func[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // source[15:0] dest[31:16] notice[63:32] code[95:64] param[127:96] count[134:128]
   // zero fill
   output logic [135:0]      rsp_tdata,
   // status[2:0]
   output logic [2:0]        rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [31:0]  csr_wdata
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [1:0]       func_ff, func_in;
   logic [31:0]      quit_ff, quit_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             out_valid_ff, out_valid_in;
   logic [2:0]       status_ff, status_in;
   logic [134:0]     out_ff, out_in;

   logic      cv [DEPTH];
   entry_type ce [DEPTH];
   logic      cg [DEPTH];
   logic      cd [DEPTH];
   logic      ch [DEPTH];
   logic      any_dup, any_hit, full, out_free, do_ins, do_pop, do_rem;
   entry_type head;

   always_comb begin
      any_dup = 1'b0;
      for (int k = 0; k < DEPTH; k++) any_dup = any_dup | cd[k];
   end
   assign any_hit = ch[DEPTH-1];
   assign full = (fill_ff == CNT_W'(DEPTH));
   assign head = ce[0];
   assign out_free = !out_valid_ff || rsp_tready;
   assign do_ins = (state_ff == S_EXEC) && out_free && (func_ff == FUNC_INSERT) &&
                   !any_dup && !full;
   assign do_pop = (state_ff == S_EXEC) && out_free && (func_ff == FUNC_POP) &&
                   (fill_ff != '0);
   assign do_rem = (state_ff == S_SCAN) && any_hit;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         peqd_cell u_cell (
            .clock(clock), .reset(reset), .cmd(cmd_ff),
            .do_insert(do_ins), .do_pop(do_pop), .do_remove(do_rem),
            .prev_valid(g == 0 ? 1'b0 : cv[(g == 0) ? 0 : g-1]),
            .prev_entry(ce[(g == 0) ? 0 : g-1]),
            .prev_ge(g == 0 ? 1'b1 : cg[(g == 0) ? 0 : g-1]),
            .prev_hit(g == 0 ? 1'b0 : ch[(g == 0) ? 0 : g-1]),
            .next_valid(g == DEPTH-1 ? 1'b0 : cv[(g == DEPTH-1) ? g : g+1]),
            .next_entry(ce[(g == DEPTH-1) ? g : g+1]),
            .valid(cv[g]), .entry(ce[g]), .ge(cg[g]), .dup(cd[g]), .hit_upto(ch[g]));
      end
   endgenerate

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff};
   assign rsp_tuser  = status_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      func_in = func_ff;
      quit_in = csr_we ? csr_wdata : quit_ff;
      fill_in = fill_ff;
      rem_in = rem_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      status_in = status_ff;
      out_in = out_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tuser;
               cmd_in.unique_mode = req_tdata[144];
               cmd_in.item.source = req_tdata[15:0];
               cmd_in.item.dest = req_tdata[31:16];
               cmd_in.item.notice = req_tdata[63:32];
               cmd_in.item.code = req_tdata[95:64];
               cmd_in.item.param = req_tdata[127:96];
               cmd_in.item.prio = req_tdata[143:128];
               rem_in = '0;
               state_in = (req_tuser == FUNC_REMOVE) ? S_SCAN : S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               status_in = ST_EMPTY;
               out_in = {fill_ff, 128'd0};
               unique case (func_ff)
                  FUNC_INSERT: begin
                     if (any_dup) status_in = ST_DUP;
                     else if (full) status_in = ST_FULL;
                     else begin
                        fill_in = fill_ff + 1'b1;
                        status_in = ST_INSERTED;
                        out_in = {fill_in, 128'd0};
                     end
                  end
                  FUNC_POP: begin
                     if (fill_ff != '0) begin
                        fill_in = fill_ff - 1'b1;
                        if (head.code == quit_ff) begin
                           status_in = ST_QUIT;
                           out_in = {fill_in, head.param, 96'd0};
                        end else begin
                           status_in = ST_EVENT;
                           out_in = {fill_in, head.param, head.code, head.notice,
                                     head.dest, head.source};
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (any_hit) begin
               fill_in = fill_ff - 1'b1;
               rem_in = rem_ff + 1'b1;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               status_in = ST_REMOVED;
               out_in = {rem_ff, 128'd0};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         quit_ff <= QUIT_RESET;
         fill_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         quit_ff <= quit_in;
         fill_ff <= fill_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff <= cmd_in;
      func_ff <= func_in;
      rem_ff <= rem_in;
      status_ff <= status_in;
      out_ff <= out_in;
   end

`ifndef SYNTHESIS
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH)) else $error("fill count above depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("accept while busy");
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && fill_ff != '0 |-> cv[0]) else $error("head lost");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// File: src/peqd_cell.sv
`default_nettype none
module peqd_cell
   import peqd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cmd_type   cmd,
   input  wire logic      do_insert,
   input  wire logic      do_pop,
   input  wire logic      do_remove,
   input  wire logic      prev_valid,
   input  wire entry_type prev_entry,
   input  wire logic      prev_ge,
   input  wire logic      prev_hit,
   input  wire logic      next_valid,
   input  wire entry_type next_entry,
   output logic           valid,
   output entry_type      entry,
   output logic           ge,
   output logic           dup,
   output logic           hit_upto
);
   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      hit;

   assign valid = valid_ff;
   assign entry = entry_ff;
   assign ge  = valid_ff && (entry_ff.prio >= cmd.item.prio);
   assign dup = valid_ff && cmd.unique_mode && entry_ff.prio == cmd.item.prio &&
                entry_ff.source == cmd.item.source && entry_ff.code == cmd.item.code &&
                entry_ff.dest == cmd.item.dest;
   assign hit = valid_ff && (cmd.item.dest == 16'd0 || entry_ff.dest == cmd.item.dest) &&
                (cmd.item.source == 16'd0 || entry_ff.source == cmd.item.source);
   assign hit_upto = prev_hit || hit;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (do_insert) begin
         if (!ge) begin
            if (prev_ge) begin
               valid_in = 1'b1;
               entry_in = cmd.item;
            end else if (prev_valid) begin
               valid_in = 1'b1;
               entry_in = prev_entry;
            end
         end
      end else if (do_pop || (do_remove && hit_upto)) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end
endmodule
`default_nettype wire
